### rtl/core/ppmdec_pkg.sv
// Shared types and constants for the PPM image stream decoder.
`default_nettype none
package ppmdec_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } ppmdec_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  max_value;
    logic [2:0]  error_code;
    logic        last_of_run;
  } ppmdec_out_t;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_PIXELS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BYTE  = 3'd1,
    ST_DIV   = 3'd2,
    ST_EOF   = 3'd3,
    ST_EOFD  = 3'd4,
    ST_EMIT  = 3'd5
  } seq_t;

  localparam logic [1:0] KIND_HDR_ASCII = 2'd0;
  localparam logic [1:0] KIND_HDR_BIN   = 2'd1;
  localparam logic [1:0] KIND_PIXEL     = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [2:0] ERR_MAGIC      = 3'd0;
  localparam logic [2:0] ERR_INTEGER    = 3'd1;
  localparam logic [2:0] ERR_SIZE       = 3'd2;
  localparam logic [2:0] ERR_MAXVAL     = 3'd3;
  localparam logic [2:0] ERR_RANGE      = 3'd4;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd5;

  localparam logic [16:0] TOKEN_SAT = 17'h1FFFF;
  localparam logic [15:0] MAGIC_P3  = 16'h5033;
  localparam logic [15:0] MAGIC_P6  = 16'h5036;

endpackage
`default_nettype wire

### rtl/core/ppm_image_stream_decoder_unit.sv
// Top level of the PPM (P3/P6) image stream decoder.
`default_nettype none
// Usage:
//   One file byte is a beat on the byte channel (byte_valid / byte_stall), with
//   start_of_file clearing all parser state before that byte and end_of_file
//   marking the last byte. Results (header, pixel, error) leave on the result
//   channel (result_valid / result_stall); a byte yields zero, one or two
//   results, and last_of_run flags the final one of a byte.
// Sequencing:
//   A byte that only advances the tokenizer passes through the accept, the
//   byte step, the end-of-file close and the incomplete check. A byte that
//   completes a sample also runs the shared radix-2 restoring divider, one
//   quotient bit per cycle, and then a write-back step. Each result is held
//   in the output register for as long as the receiver stalls it; no byte is
//   accepted meanwhile.
// Reset:
//   rst is synchronous. It puts the parser at the magic token and drops any
//   pending result. After any error the block ignores bytes until a byte
//   arrives with start_of_file set.
module ppm_image_stream_decoder_unit
  import ppmdec_pkg::*;
#(
  parameter int MAX_DIM = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire ppmdec_in_t  byte_data,
  output logic             result_valid,
  input  wire logic        result_stall,
  output ppmdec_out_t      result_data
);

  localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

  seq_t st, st_next;
  // Parser state.
  phase_t      phase;
  logic        bin_fmt, in_comment, tok_neg, tok_started, tok_invalid, tok_digits;
  logic [16:0] tok_val;
  logic [15:0] magic_chars;
  logic [1:0]  magic_len;
  logic [15:0] width_reg, height_reg, column, row;
  logic [7:0]  maxv;
  logic [1:0]  comp;
  logic [7:0]  red_hold, green_hold;
  logic        range_fault, cr_seen, stopped;
  // Latched byte and pending work.
  logic [7:0]  cur_byte;
  logic        cur_eof;
  logic        samp_bad;
  logic        after_eof;      // return to EOF handling after division
  // Divider.
  logic [16:0] div_num, div_rem;
  logic [8:0]  div_den;
  logic [3:0]  div_cnt;
  logic [9:0]  div_q;
  // Output queue of up to two results.
  ppmdec_out_t res0, res1;
  logic [1:0]  res_cnt;
  logic        res_idx;

  // Combinational parse step outputs.
  logic        is_ws;

  assign byte_stall   = (st != ST_IDLE);
  assign result_valid = (st == ST_EMIT);
  always_comb begin
    result_data = res_idx ? res1 : res0;
    result_data.last_of_run = ({1'b0, res_idx} == res_cnt - 2'd1);
  end

  assign is_ws = (cur_byte == 8'h20) || (cur_byte >= 8'd9 && cur_byte <= 8'd13);

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (byte_valid) st_next = ST_BYTE;
      ST_BYTE, ST_EOF, ST_EOFD, ST_DIV, ST_EMIT: st_next = st;
      default: st_next = ST_IDLE;
    endcase
  end

  // The sequencer: one byte step, optional division, end-of-file step, optional division, incomplete check, emit.
  always_ff @(posedge clk) begin
    automatic logic        a_stop, a_started, a_neg, a_good, a_sample, a_bad;
    automatic logic [16:0] a_v;
    automatic logic [16:0] a_num;
    automatic logic [16:0] nv;
    automatic logic [20:0] dprod;
    automatic logic [17:0] trial;
    automatic ppmdec_out_t r;
    if (rst) begin
      st <= ST_IDLE;
      phase <= PH_MAGIC; stopped <= 1'b0; res_cnt <= 2'd0; res_idx <= 1'b0;
      after_eof <= 1'b0; bin_fmt <= 1'b0;
      in_comment <= 1'b0; tok_started <= 1'b0; tok_val <= '0; tok_neg <= 1'b0;
      tok_invalid <= 1'b0; tok_digits <= 1'b0; magic_chars <= '0; magic_len <= '0;
      cr_seen <= 1'b0; comp <= '0; range_fault <= 1'b0;
      width_reg <= '0; height_reg <= '0; maxv <= '0; column <= '0; row <= '0;
      red_hold <= '0; green_hold <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          res_cnt <= 2'd0; res_idx <= 1'b0;
          if (byte_valid) begin
            cur_byte <= byte_data.data_byte;
            cur_eof  <= byte_data.end_of_file;
            if (byte_data.start_of_file) begin
              phase <= PH_MAGIC; bin_fmt <= 1'b0; in_comment <= 1'b0;
              tok_val <= '0; tok_neg <= 1'b0; tok_started <= 1'b0;
              tok_invalid <= 1'b0; tok_digits <= 1'b0; magic_chars <= '0;
              magic_len <= '0; width_reg <= '0; height_reg <= '0; maxv <= '0;
              column <= '0; row <= '0; comp <= '0; red_hold <= '0;
              green_hold <= '0; range_fault <= 1'b0; cr_seen <= 1'b0;
              stopped <= 1'b0;
            end
            st <= ST_BYTE;
          end
        end
        ST_BYTE, ST_EOF: begin
          // Token processing for the byte, or for the end-of-file close.
          a_sample = 1'b0; a_bad = 1'b0; a_v = '0; a_stop = 1'b0;
          r = '0;
          if (stopped || phase == PH_DONE) begin
            st <= (st == ST_BYTE) ? ST_EOF : ST_EOFD;
          end else if (st == ST_EOF && !cur_eof) begin
            st <= ST_EOFD;
          end else begin
            automatic logic tokz = (phase <= PH_MAXVAL) || (phase == PH_PIXELS && !bin_fmt);
            automatic logic fin = 1'b0;
            if (st == ST_EOF) begin
              fin = tokz && tok_started;
            end else if (tokz) begin
              if (in_comment) begin
                if (cur_byte == 8'h0A) in_comment <= 1'b0;
              end else if (is_ws) begin
                fin = tok_started;
              end else if (cur_byte == 8'h23) begin
                fin = tok_started;
                in_comment <= 1'b1;
              end else begin
                tok_started <= 1'b1;
                if (phase == PH_MAGIC) begin
                  if (magic_len < 2'd2) magic_chars <= {magic_chars[7:0], cur_byte};
                  if (magic_len < 2'd3) magic_len <= magic_len + 2'd1;
                end else if (!tok_started && (cur_byte == 8'h2B || cur_byte == 8'h2D)) begin
                  tok_neg <= (cur_byte == 8'h2D);
                end else if (cur_byte >= 8'h30 && cur_byte <= 8'h39) begin
                  // Decimal accumulate, saturating at the token limit.
                  dprod = {4'b0, tok_val} * 21'd10 + {13'b0, cur_byte - 8'h30};
                  nv = (dprod > {4'b0, TOKEN_SAT}) ? TOKEN_SAT : dprod[16:0];
                  tok_val <= nv;
                  tok_digits <= 1'b1;
                end else begin
                  tok_invalid <= 1'b1;
                end
              end
            end else if (in_comment) begin
              if (cur_byte == 8'h0A) in_comment <= 1'b0;
            end else if (cr_seen) begin
              cr_seen <= 1'b0;
              if (cur_byte != 8'h0A) begin
                a_sample = 1'b1; a_v = {9'b0, cur_byte}; a_bad = cur_byte > maxv;
              end
            end else begin
              a_sample = 1'b1; a_v = {9'b0, cur_byte}; a_bad = cur_byte > maxv;
            end
            if (fin) begin
              a_good = tok_digits && !tok_invalid;
              a_neg  = tok_neg && (tok_val != 17'd0);
              tok_started <= 1'b0; tok_val <= '0; tok_neg <= 1'b0;
              tok_invalid <= 1'b0; tok_digits <= 1'b0;
              unique case (phase)
                PH_MAGIC: begin
                  if (magic_len == 2'd2 && (magic_chars == MAGIC_P3 || magic_chars == MAGIC_P6))
                  begin
                    bin_fmt <= (magic_chars == MAGIC_P6);
                    phase <= PH_WIDTH;
                  end else begin
                    a_stop = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_MAGIC;
                  end
                  magic_chars <= '0; magic_len <= '0;
                end
                PH_WIDTH, PH_HEIGHT: begin
                  if (!a_good) begin
                    a_stop = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_INTEGER;
                  end else if (phase == PH_WIDTH) begin
                    width_reg <= (a_neg || tok_val > MAX_DIM_V) ? 16'd0 : tok_val[15:0];
                    phase <= PH_HEIGHT;
                  end else begin
                    height_reg <= (a_neg || tok_val > MAX_DIM_V) ? 16'd0 : tok_val[15:0];
                    phase <= PH_MAXVAL;
                  end
                end
                PH_MAXVAL: begin
                  a_stop = 1'b1; r.result_kind = KIND_ERROR;
                  if (!a_good) r.error_code = ERR_INTEGER;
                  else if (width_reg == 16'd0 || height_reg == 16'd0) r.error_code = ERR_SIZE;
                  else if (a_neg || tok_val == 17'd0 || tok_val > 17'd255)
                    r.error_code = ERR_MAXVAL;
                  else begin
                    a_stop = 1'b0;
                    r.result_kind = bin_fmt ? KIND_HDR_BIN : KIND_HDR_ASCII;
                    r.image_width = width_reg; r.image_height = height_reg;
                    r.max_value = tok_val[7:0];
                    maxv <= tok_val[7:0];
                    column <= '0; row <= '0; comp <= '0; range_fault <= 1'b0;
                    phase <= PH_PIXELS;
                    if (st == ST_BYTE && cur_byte == 8'h0D && bin_fmt) cr_seen <= 1'b1;
                  end
                end
                default: begin
                  if (!a_good) begin
                    a_stop = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_INTEGER;
                  end else begin
                    a_sample = 1'b1; a_v = tok_val;
                    a_bad = a_neg || (tok_val > {9'b0, maxv});
                  end
                end
              endcase
            end
            if (a_stop) stopped <= 1'b1;
            if (a_stop || (fin && phase == PH_MAXVAL)) begin
              if (res_cnt == 2'd0) res0 <= r; else res1 <= r;
              res_cnt <= res_cnt + 2'd1;
            end
            after_eof <= (st == ST_EOF);
            if (a_sample) begin
              // Numerator v*510 + max; for an in-range sample the quotient fits in 10
              // bits, so the bits above the low ten preload the remainder.
              a_num = {a_v[7:0], 9'b0} - {8'b0, a_v[7:0], 1'b0} + {9'b0, maxv};
              samp_bad <= a_bad;
              div_num <= a_num;
              div_den <= {maxv, 1'b0};
              div_rem <= {10'b0, a_num[16:10]}; div_q <= '0; div_cnt <= '0;
              st <= ST_DIV;
            end else begin
              st <= (st == ST_BYTE) ? ST_EOF : ST_EOFD;
            end
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (div_cnt != 4'd10) begin
            trial = {div_rem, div_num[9]} - {9'b0, div_den};
            if (!trial[17]) begin
              div_rem <= trial[16:0]; div_q <= {div_q[8:0], 1'b1};
            end else begin
              div_rem <= {div_rem[15:0], div_num[9]}; div_q <= {div_q[8:0], 1'b0};
            end
            div_num <= {div_num[15:0], 1'b0};
            div_cnt <= div_cnt + 4'd1;
          end else begin
            automatic logic [7:0] s = samp_bad ? 8'd0 : div_q[7:0];
            r = '0;
            st <= after_eof ? ST_EOFD : ST_EOF;
            if (comp == 2'd0) begin
              range_fault <= samp_bad; red_hold <= s; comp <= 2'd1;
            end else if (comp == 2'd1) begin
              range_fault <= range_fault | samp_bad; green_hold <= s; comp <= 2'd2;
            end else begin
              comp <= 2'd0;
              if (range_fault || samp_bad) begin
                stopped <= 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_RANGE;
              end else begin
                r.result_kind = KIND_PIXEL; r.red = red_hold; r.green = green_hold;
                r.blue = s; r.pixel_x = column; r.pixel_y = row;
                if (17'(column) + 17'd1 >= 17'(width_reg)) begin
                  column <= '0; row <= row + 16'd1;
                  if (17'(row) + 17'd1 >= 17'(height_reg)) phase <= PH_DONE;
                end else begin
                  column <= column + 16'd1;
                end
              end
              if (res_cnt == 2'd0) res0 <= r; else res1 <= r;
              res_cnt <= res_cnt + 2'd1;
            end
          end
        end
        ST_EOFD: begin
          // Incomplete image at end of file.
          r = '0;
          if (cur_eof && !stopped && phase != PH_DONE) begin
            stopped <= 1'b1;
            r.result_kind = KIND_ERROR; r.error_code = ERR_INCOMPLETE;
            if (res_cnt == 2'd0) res0 <= r; else res1 <= r;
            st <= ST_EMIT;
            res_cnt <= res_cnt + 2'd1;
          end else begin
            st <= (res_cnt == 2'd0) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!result_stall) begin
            if ({1'b0, res_idx} == res_cnt - 2'd1) st <= ST_IDLE;
            else res_idx <= 1'b1;
          end
        end
        default: st <= st_next;
      endcase
    end
  end

endmodule
`default_nettype wire

### test/ppm_image_stream_decoder_unit_tb.sv
// Self-checking testbench for the PPM image stream decoder top level.
`timescale 1ns / 1ps
module ppm_image_stream_decoder_unit_tb
  import ppmdec_pkg::*;
;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_stall;
  ppmdec_in_t byte_data;
  logic result_valid;
  logic result_stall;
  ppmdec_out_t result_data;

  ppm_image_stream_decoder_unit uut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_data(byte_data),
    .result_valid(result_valid), .result_stall(result_stall), .result_data(result_data)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the decoder state.
  phase_t      sh_phase;
  logic        sh_binary, sh_comment, sh_tok_neg, sh_tok_started, sh_tok_invalid;
  logic        sh_tok_digits, sh_range_fault, sh_cr_seen, sh_stopped;
  logic [16:0] sh_tok_value;
  logic [15:0] sh_magic;
  logic [1:0]  sh_magic_len, sh_comp;
  logic [15:0] sh_width, sh_height, sh_col, sh_row;
  logic [7:0]  sh_maxval, sh_red, sh_green;

  ppmdec_out_t expected_results[$];
  ppmdec_out_t step_results[$];

  int send_pct;
  int stall_pct;
  int error_count = 0;
  int beats_sent;
  int results_seen = 0;
  int pixels_seen = 0;
  int errors_seen = 0;
  int headers_seen = 0;
  longint cycle_count = 0;

  task automatic clear_decoder_state();
    sh_phase = PH_MAGIC;
    sh_binary = 0; sh_comment = 0; sh_tok_neg = 0; sh_tok_started = 0;
    sh_tok_invalid = 0; sh_tok_digits = 0; sh_range_fault = 0; sh_cr_seen = 0;
    sh_stopped = 0; sh_tok_value = 0; sh_magic = 0; sh_magic_len = 0;
    sh_comp = 0; sh_width = 0; sh_height = 0; sh_col = 0; sh_row = 0;
    sh_maxval = 0; sh_red = 0; sh_green = 0;
  endtask

  // Adds a result to this beat's list; beyond two it is dropped.
  task automatic add_result(ppmdec_out_t r);
    if (step_results.size() < 2) step_results = {step_results, r};
  endtask

  task automatic raise_error(logic [2:0] code);
    ppmdec_out_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    add_result(r);
    sh_stopped = 1;
  endtask

  // Rounded rescale of a sample to 0..255.
  function automatic logic [7:0] rescale(logic [16:0] v);
    logic [31:0] m;
    m = sh_maxval;
    if (m == 0) return 8'd0;
    return 8'((32'(v) * 510 + m) / (2 * m));
  endfunction

  task automatic take_sample(logic [16:0] v, logic bad);
    logic [7:0] s;
    ppmdec_out_t r;
    s = bad ? 8'd0 : rescale(v);
    if (sh_comp == 0) begin
      sh_range_fault = bad;
      sh_red = s;
      sh_comp = 1;
    end else if (sh_comp == 1) begin
      sh_range_fault |= bad;
      sh_green = s;
      sh_comp = 2;
    end else begin
      sh_comp = 0;
      if (sh_range_fault || bad) begin
        raise_error(ERR_RANGE);
      end else begin
        r = '0;
        r.result_kind = KIND_PIXEL;
        r.red = sh_red;
        r.green = sh_green;
        r.blue = s;
        r.pixel_x = sh_col;
        r.pixel_y = sh_row;
        add_result(r);
        // Position counters compare one bit wider so the last column wraps.
        if (17'(sh_col) + 17'd1 >= 17'(sh_width)) begin
          sh_col = 0;
          if (17'(sh_row) + 17'd1 >= 17'(sh_height)) sh_phase = PH_DONE;
          sh_row++;
        end else begin
          sh_col++;
        end
      end
    end
  endtask

  task automatic end_token();
    logic good;
    logic neg;
    logic [16:0] v;
    ppmdec_out_t r;
    good = sh_tok_digits && !sh_tok_invalid;
    neg = sh_tok_neg && sh_tok_value != 0;
    v = sh_tok_value;
    sh_tok_started = 0; sh_tok_value = 0; sh_tok_neg = 0;
    sh_tok_invalid = 0; sh_tok_digits = 0;
    if (sh_phase == PH_MAGIC) begin
      if (sh_magic_len == 2 && (sh_magic == MAGIC_P3 || sh_magic == MAGIC_P6)) begin
        sh_binary = (sh_magic == MAGIC_P6);
        sh_phase = PH_WIDTH;
      end else begin
        raise_error(ERR_MAGIC);
      end
      sh_magic = 0;
      sh_magic_len = 0;
    end else if (!good) begin
      raise_error(ERR_INTEGER);
    end else if (sh_phase == PH_WIDTH || sh_phase == PH_HEIGHT) begin
      if (sh_phase == PH_WIDTH) begin
        sh_width = (neg || v > 65535) ? 16'd0 : v[15:0];
        sh_phase = PH_HEIGHT;
      end else begin
        sh_height = (neg || v > 65535) ? 16'd0 : v[15:0];
        sh_phase = PH_MAXVAL;
      end
    end else if (sh_phase == PH_MAXVAL) begin
      if (sh_width == 0 || sh_height == 0) begin
        raise_error(ERR_SIZE);
      end else if (neg || v == 0 || v > 255) begin
        raise_error(ERR_MAXVAL);
      end else begin
        sh_maxval = v[7:0];
        r = '0;
        r.result_kind = sh_binary ? KIND_HDR_BIN : KIND_HDR_ASCII;
        r.image_width = sh_width;
        r.image_height = sh_height;
        r.max_value = sh_maxval;
        add_result(r);
        sh_col = 0; sh_row = 0; sh_comp = 0; sh_range_fault = 0;
        sh_phase = PH_PIXELS;
      end
    end else begin
      take_sample(v, (neg || v > sh_maxval));
    end
  endtask

  task automatic token_char(logic [7:0] c);
    logic was;
    logic [20:0] nv;
    was = sh_tok_started;
    sh_tok_started = 1;
    if (sh_phase == PH_MAGIC) begin
      if (sh_magic_len < 2) sh_magic = {sh_magic[7:0], c};
      if (sh_magic_len < 3) sh_magic_len++;
    end else if (!was && (c == "+" || c == "-")) begin
      sh_tok_neg = (c == "-");
    end else if (c >= "0" && c <= "9") begin
      nv = 21'(sh_tok_value) * 21'd10 + 21'(c - "0");
      sh_tok_value = (nv > 21'(TOKEN_SAT)) ? TOKEN_SAT : nv[16:0];
      sh_tok_digits = 1;
    end else begin
      sh_tok_invalid = 1;
    end
  endtask

  function automatic logic in_text();
    return sh_phase <= PH_MAXVAL || (sh_phase == PH_PIXELS && !sh_binary);
  endfunction

  // Predicts the results of one input beat and queues them.
  task automatic decode_byte(ppmdec_in_t b);
    logic [7:0] c;
    ppmdec_out_t r;
    c = b.data_byte;
    step_results.delete();
    if (b.start_of_file) clear_decoder_state();
    if (!sh_stopped && sh_phase != PH_DONE) begin
      if (in_text()) begin
        if (sh_comment) begin
          if (c == 8'h0A) sh_comment = 0;
        end else if (c == " " || (c >= 9 && c <= 13)) begin
          if (sh_tok_started) begin
            end_token();
            if (c == 8'h0D && !sh_stopped && sh_phase == PH_PIXELS && sh_binary)
              sh_cr_seen = 1;
          end
        end else if (c == "#") begin
          if (sh_tok_started) end_token();
          sh_comment = 1;
        end else begin
          token_char(c);
        end
      end else if (sh_comment) begin
        if (c == 8'h0A) sh_comment = 0;
      end else if (sh_cr_seen) begin
        sh_cr_seen = 0;
        if (c != 8'h0A) take_sample(17'(c), c > sh_maxval);
      end else begin
        take_sample(17'(c), c > sh_maxval);
      end
    end
    if (b.end_of_file && !sh_stopped && sh_phase != PH_DONE) begin
      if (in_text() && sh_tok_started) end_token();
      if (!sh_stopped && sh_phase != PH_DONE) raise_error(ERR_INCOMPLETE);
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.last_of_run = (i == step_results.size() - 1);
      expected_results = {expected_results, r};
    end
  endtask

  // Sends one beat, idling at random beforehand, and predicts its results.
  task automatic send_byte(logic [7:0] c, logic sof = 0, logic eof = 0);
    ppmdec_in_t b;
    b.data_byte = c;
    b.start_of_file = sof;
    b.end_of_file = eof;
    while ($urandom_range(99) < send_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_byte(b);
    beats_sent++;
  endtask

  task automatic send_text(string s, logic sof = 1, logic eof = 0);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], sof && i == 0, eof && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    ppmdec_out_t e;
    cycle_count++;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", result_data.result_kind);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (e.result_kind == KIND_PIXEL) pixels_seen++;
        if (e.result_kind == KIND_ERROR) errors_seen++;
        if (e.result_kind <= KIND_HDR_BIN) headers_seen++;
        if (result_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, result_data.result_kind);
          error_count++;
        end
        if (result_data.red !== e.red) begin
          $error("red exp %0d got %0d", e.red, result_data.red); error_count++;
        end
        if (result_data.green !== e.green) begin
          $error("green exp %0d got %0d", e.green, result_data.green); error_count++;
        end
        if (result_data.blue !== e.blue) begin
          $error("blue exp %0d got %0d", e.blue, result_data.blue); error_count++;
        end
        if (result_data.pixel_x !== e.pixel_x) begin
          $error("pixel_x exp %0d got %0d", e.pixel_x, result_data.pixel_x); error_count++;
        end
        if (result_data.pixel_y !== e.pixel_y) begin
          $error("pixel_y exp %0d got %0d", e.pixel_y, result_data.pixel_y); error_count++;
        end
        if (result_data.image_width !== e.image_width) begin
          $error("image_width exp %0d got %0d", e.image_width, result_data.image_width);
          error_count++;
        end
        if (result_data.image_height !== e.image_height) begin
          $error("image_height exp %0d got %0d", e.image_height, result_data.image_height);
          error_count++;
        end
        if (result_data.max_value !== e.max_value) begin
          $error("max_value exp %0d got %0d", e.max_value, result_data.max_value);
          error_count++;
        end
        if (result_data.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, result_data.error_code);
          error_count++;
        end
        if (result_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, result_data.last_of_run);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Header extremes, both formats, comments and the CR LF data start.
  task automatic test_directed_headers();
    send_text("P3\n2 1\n255\n0 128 255 255 0 1", 1, 1);
    send_text("P6 1 1 255\r\n");
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80, 0, 1);
    send_text("P6#c\n1 1#x\n7#z\n");
    send_byte(8'h07); send_byte(8'h00); send_byte(8'h03);
    send_text("P3 1 1 1 1 0 +1 junk", 1, 1);
    send_text("P3\t-0 1 3\n", 1, 1);
    send_text("P3 65535 65536 1 ", 1, 1);
    send_text("P3 65535 1 255 9 9 -9", 1, 1);
  endtask

  // Every error code but the size error, and the token corner cases.
  task automatic test_directed_errors();
    send_text("P5 ", 1, 0);
    send_text("P33 1 1 1", 1, 1);
    send_text("P3 1x 1 1", 1, 1);
    send_text("P3 1 1 0 ", 1, 1);
    send_text("P3 1 1 256 ", 1, 1);
    send_text("P3 1 1 999999 ", 1, 1);
    send_text("P3 1 1 2 3 0 0 ", 1, 1);
    send_text("P3 1 1 2 1 1", 1, 1);
    send_text("P3 1 1 + ", 1, 1);
  endtask

  // Mostly well-formed random images with a share of corrupted bytes.
  task automatic random_file();
    int w, h, mv, noise;
    logic bin;
    string s;
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    mv = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 255);
    bin = 1'($urandom_range(1));
    noise = $urandom_range(7);
    s = $sformatf("%s %0d\n%0d #n\n%0d%s", bin ? "P6" : "P3", w, h, mv,
                  ($urandom_range(2) == 0) ? "\r\n" : " ");
    for (int i = 0; i < s.len(); i++)
      send_byte((noise == 0 && $urandom_range(20) == 0) ? 8'($urandom) : s[i], i == 0);
    for (int p = 0; p < w * h * 3; p++) begin
      int v;
      v = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(mv);
      if (noise == 1 && $urandom_range(30) == 0) v = $urandom_range(255);
      if (bin) begin
        send_byte(8'(v), 0, (p == w * h * 3 - 1) || (noise == 2 && $urandom_range(40) == 0));
      end else begin
        s = (noise == 3 && $urandom_range(30) == 0) ? "-3" : $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(($urandom_range(3) == 0) ? 8'h09 : " ");
      end
    end
    if (!bin) send_byte(8'($urandom), 0, 1);
  endtask

  task automatic test_random_phase(int sp, int st, int n);
    send_pct = sp;
    stall_pct = st;
    while (n > 0) begin
      int b0;
      b0 = beats_sent;
      random_file();
      n -= beats_sent - b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    send_pct = 0; stall_pct = 0; beats_sent = 0;
    clear_decoder_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_headers();
    test_directed_errors();
    // Hold the sender until the decoder has drained.
    wait_drained();
    test_random_phase(21, 65, 200);
    test_random_phase(65, 21, 200);
    test_random_phase(0, 0, 200);
    wait_drained();
    $display("Sent %0d byte beats; checked %0d results", beats_sent, results_seen);
    $display("(%0d headers, %0d pixels, %0d errors).", headers_seen, pixels_seen,
             errors_seen);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ppmdec_pkg.sv
rtl/core/ppm_image_stream_decoder_unit.sv
test/ppm_image_stream_decoder_unit_tb.sv
